[rtl/rttp_pkg.sv]
package rttp_pkg;

  localparam int unsigned TEXT_W = 8;
  localparam int unsigned NUM_W  = 16;

  localparam logic [TEXT_W-1:0] CH_NUL   = 8'h00;
  localparam logic [TEXT_W-1:0] CH_TAB   = 8'h09;
  localparam logic [TEXT_W-1:0] CH_LF    = 8'h0A;
  localparam logic [TEXT_W-1:0] CH_CR    = 8'h0D;
  localparam logic [TEXT_W-1:0] CH_SPACE = 8'h20;
  localparam logic [TEXT_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [TEXT_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [TEXT_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [TEXT_W-1:0] CH_COLON = 8'h3A;
  localparam logic [TEXT_W-1:0] CH_UC_G  = 8'h47;
  localparam logic [TEXT_W-1:0] CH_LC_G  = 8'h67;
  localparam logic [TEXT_W-1:0] CH_UC_X  = 8'h58;
  localparam logic [TEXT_W-1:0] CH_LC_X  = 8'h78;
  localparam logic [TEXT_W-1:0] CH_UC_B  = 8'h42;
  localparam logic [TEXT_W-1:0] CH_LC_B  = 8'h62;
  localparam logic [TEXT_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [TEXT_W-1:0] CH_RBRACE = 8'h7D;

  // digit offsets per character band
  localparam logic [NUM_W-1:0] OFF_DEC   = 16'h0030;
  localparam logic [NUM_W-1:0] OFF_UPPER = 16'h0037;
  localparam logic [NUM_W-1:0] OFF_LOWER = 16'h0057;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_TOKEN   = 2'd1,
    MODE_COMMENT = 2'd2
  } scan_mode_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_BIN = 2'd2
  } num_base_t;

  typedef struct packed {
    scan_mode_t        mode;
    logic [1:0]        pos;
    logic              first_zero;
    num_base_t         base;
    logic [NUM_W-1:0]  acc;
    logic              bad;
  } tok_state_t;

  localparam tok_state_t TOK_RESET = '{
    mode: MODE_BETWEEN, pos: 2'd0, first_zero: 1'b0,
    base: BASE_DEC, acc: '0, bad: 1'b0
  };

  function automatic logic is_separator(input logic [TEXT_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
           (c == CH_COMMA) || (c == CH_LBRACE) || (c == CH_RBRACE);
  endfunction

  // acc * base as shifts and adds, wrapping at NUM_W bits
  function automatic logic [NUM_W-1:0] scale(input logic [NUM_W-1:0] a,
                                             input num_base_t b);
    logic [NUM_W-1:0] r;
    case (b)
      BASE_HEX: r = a << 4;
      BASE_BIN: r = a << 1;
      default:  r = (a << 3) + (a << 1);
    endcase
    return r;
  endfunction

  // fold one token character into the token state
  function automatic tok_state_t take_char(input tok_state_t s,
                                           input logic [TEXT_W-1:0] c);
    tok_state_t       t;
    logic [NUM_W-1:0] off;
    logic             prefix;
    t = s;
    if (t.mode != MODE_TOKEN) begin
      t = TOK_RESET;
      t.mode = MODE_TOKEN;
    end
    prefix = (t.pos == 2'd1) && t.first_zero;
    if (prefix && ((c == CH_LC_X) || (c == CH_UC_X))) begin
      t.base = BASE_HEX;
      t.pos  = 2'd2;
    end else if (prefix && ((c == CH_LC_B) || (c == CH_UC_B))) begin
      t.base = BASE_BIN;
      t.pos  = 2'd2;
    end else begin
      if (c >= CH_LC_G) begin
        t.bad = 1'b1;
      end else begin
        if (c < CH_COLON)     off = OFF_DEC;
        else if (c < CH_UC_G) off = OFF_UPPER;
        else                  off = OFF_LOWER;
        t.acc = scale(t.acc, t.base) + {{(NUM_W-TEXT_W){1'b0}}, c} - off;
      end
      if (t.pos == 2'd0) t.first_zero = (c == CH_ZERO);
      if (t.pos != 2'd2) t.pos = t.pos + 2'd1;
    end
    return t;
  endfunction

endpackage

[rtl/rttp_if.sv]
interface rttp_in_if;
  import rttp_pkg::*;

  logic              valid;
  logic              ready;
  logic [TEXT_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface rttp_out_if;
  import rttp_pkg::*;

  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] number_value;
  logic             bad_character;

  modport source (output valid, output number_value, output bad_character, input ready);
  modport sink   (input valid, input number_value, input bad_character, output ready);
endinterface

[rtl/register_text_token_parser.sv]
// Register-table text parser: one text byte per request on in_ch, one
// number per finished token on out_ch (16-bit value, bad-character flag).
// Tokens split on space, tab, CR, LF, comma and braces; "//" starts a
// comment up to LF; a zero byte ends the text and returns the parser to
// its reset state. Hex after 0x/0X, binary after 0b/0B, else decimal.
// A byte taken on in_ch waits in the input stage; the parse stage then
// folds it in, and its number (if any) is registered onto out_ch.
// Throughput: one byte per cycle unless out_ch stalls; a byte after a
// slash may fold two characters in one cycle (two shift-add steps).
// Reset (rst_n low, synchronous): input stage and output register empty,
// parser between tokens with no slash pending.
// Stall: when out_ch holds a number that is not taken, the parse stage
// waits, the input stage fills, and in_ch.ready drops; nothing is lost.
module register_text_token_parser (
  input  logic           clk,
  input  logic           rst_n,
  rttp_in_if.sink        in_ch,
  rttp_out_if.source     out_ch
);
  import rttp_pkg::*;

  // input stage
  logic              in_valid_r;
  logic [TEXT_W-1:0] in_byte_r;

  // parser state
  tok_state_t        st_r, st_nxt;
  logic              slash_r, slash_nxt;

  // result register
  logic              out_valid_r;
  logic [NUM_W-1:0]  out_value_r;
  logic              out_bad_r;

  logic              emit;
  logic [NUM_W-1:0]  emit_value;
  logic              emit_bad;
  logic              advance;

  // parse stage moves whenever the result slot is free or being drained
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;

  // next parser state for the byte in the input stage
  always_comb begin
    tok_state_t t;
    logic       done;
    t          = st_r;
    done       = 1'b0;
    st_nxt     = st_r;
    slash_nxt  = slash_r;
    emit       = 1'b0;
    emit_value = '0;
    emit_bad   = 1'b0;
    if (st_r.mode == MODE_COMMENT) begin
      // comments swallow everything up to LF or end of text
      if (in_byte_r == CH_NUL) begin
        st_nxt    = TOK_RESET;
        slash_nxt = 1'b0;
      end else if (in_byte_r == CH_LF) begin
        st_nxt.mode = MODE_BETWEEN;
      end
    end else begin
      if (slash_r) begin
        slash_nxt = 1'b0;
        if (in_byte_r == CH_SLASH) begin
          // double slash: close any open token, enter comment
          emit        = (st_r.mode == MODE_TOKEN);
          st_nxt.mode = MODE_COMMENT;
          done        = 1'b1;
        end else begin
          // lone slash was a token character after all
          t = take_char(st_r, CH_SLASH);
        end
      end
      if (!done) begin
        if (in_byte_r == CH_NUL) begin
          emit      = (t.mode == MODE_TOKEN);
          st_nxt    = TOK_RESET;
          slash_nxt = 1'b0;
        end else if (in_byte_r == CH_SLASH) begin
          st_nxt    = t;
          slash_nxt = 1'b1;
        end else if (is_separator(in_byte_r)) begin
          emit        = (t.mode == MODE_TOKEN);
          st_nxt      = t;
          st_nxt.mode = MODE_BETWEEN;
        end else begin
          st_nxt = take_char(t, in_byte_r);
        end
      end
      emit_bad   = t.bad;
      emit_value = t.bad ? '0 : t.acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= TOK_RESET;
      slash_r     <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r && emit;
        if (in_valid_r) begin
          st_r    <= st_nxt;
          slash_r <= slash_nxt;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.text_byte;
    end
    if (advance && in_valid_r && emit) begin
      out_value_r <= emit_value;
      out_bad_r   <= emit_bad;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.number_value  = out_value_r;
  assign out_ch.bad_character = out_bad_r;

endmodule

[verif/register_text_token_parser_checker.sv]
module register_text_token_parser_checker (
  input  logic clk,
  input  logic rst_n,
  rttp_in_if   in_ch,
  rttp_out_if  out_ch,
  output int   mismatch_count,
  output int   numbers_waiting,
  output int   numbers_checked,
  output int   flagged_numbers
);
  import rttp_pkg::*;

  typedef struct packed {
    logic [NUM_W-1:0] value;
    logic             bad;
  } parsed_number_t;

  parsed_number_t expected_numbers[$];

  // shadow copy of the tokenizer
  scan_mode_t       mode;
  logic             slash_seen;
  logic [1:0]       char_count;
  logic             lead_zero;
  num_base_t        radix;
  logic [NUM_W-1:0] value_acc;
  logic             bad_flag;

  function automatic logic is_text_break(input logic [TEXT_W-1:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_COMMA, CH_LBRACE, CH_RBRACE};
  endfunction

  task automatic clear_parser();
    mode       = MODE_BETWEEN;
    slash_seen = 1'b0;
    char_count = 2'd0;
    lead_zero  = 1'b0;
    radix      = BASE_DEC;
    value_acc  = '0;
    bad_flag   = 1'b0;
  endtask

  task automatic finish_token();
    expected_numbers.push_back('{value: bad_flag ? '0 : value_acc, bad: bad_flag});
    mode = MODE_BETWEEN;
  endtask

  task automatic fold_char(input logic [TEXT_W-1:0] c);
    logic [NUM_W-1:0] weight;
    logic [NUM_W-1:0] bias;
    logic             after_zero;
    if (mode != MODE_TOKEN) begin
      clear_parser();
      mode = MODE_TOKEN;
    end
    after_zero = (char_count == 2'd1) && lead_zero;
    if (after_zero && (c == CH_LC_X || c == CH_UC_X)) begin
      radix      = BASE_HEX;
      char_count = 2'd2;
    end else if (after_zero && (c == CH_LC_B || c == CH_UC_B)) begin
      radix      = BASE_BIN;
      char_count = 2'd2;
    end else begin
      if (c >= CH_LC_G) begin
        bad_flag = 1'b1;
      end else begin
        case (radix)
          BASE_HEX: weight = 16'd16;
          BASE_BIN: weight = 16'd2;
          default:  weight = 16'd10;
        endcase
        // band decides the offset, base is never checked
        if (c < CH_COLON)     bias = OFF_DEC;
        else if (c < CH_UC_G) bias = OFF_UPPER;
        else                  bias = OFF_LOWER;
        value_acc = value_acc * weight + NUM_W'(c) - bias;
      end
      if (char_count == 2'd0) lead_zero = (c == CH_ZERO);
      if (char_count != 2'd2) char_count = char_count + 2'd1;
    end
  endtask

  task automatic predict_byte(input logic [TEXT_W-1:0] c);
    logic handled;
    handled = 1'b0;
    if (mode == MODE_COMMENT) begin
      if (c == CH_NUL)     clear_parser();
      else if (c == CH_LF) mode = MODE_BETWEEN;
      handled = 1'b1;
    end else if (slash_seen) begin
      slash_seen = 1'b0;
      if (c == CH_SLASH) begin
        // token cut short by a comment still counts
        if (mode == MODE_TOKEN) finish_token();
        mode    = MODE_COMMENT;
        handled = 1'b1;
      end else begin
        fold_char(CH_SLASH);
      end
    end
    if (!handled) begin
      if (c == CH_NUL) begin
        if (mode == MODE_TOKEN) finish_token();
        clear_parser();
      end else if (c == CH_SLASH) begin
        slash_seen = 1'b1;
      end else if (is_text_break(c)) begin
        if (mode == MODE_TOKEN) finish_token();
      end else begin
        fold_char(c);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    parsed_number_t want;
    if (!rst_n) begin
      clear_parser();
      expected_numbers.delete();
      mismatch_count  = 0;
      numbers_checked = 0;
      flagged_numbers = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_numbers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected number: value %h bad %b",
                     out_ch.number_value, out_ch.bad_character);
        end else begin
          want = expected_numbers.pop_front();
          numbers_checked++;
          if (want.bad) flagged_numbers++;
          if (out_ch.number_value !== want.value || out_ch.bad_character !== want.bad) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("number mismatch: expected value %h bad %b, got value %h bad %b",
                       want.value, want.bad, out_ch.number_value, out_ch.bad_character);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.text_byte);
    end
    numbers_waiting = expected_numbers.size();
  end

endmodule

[verif/register_text_token_parser_tb.sv]
module register_text_token_parser_tb;
  import rttp_pkg::*;

  // Longest correct quiet stretch is the receiver hold-off (HOLD_CYCLES)
  // plus a few random gaps; this is several times that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 120;
  localparam int PHASE_BYTES    = 190;

  logic clk = 1'b0;
  logic rst_n;

  rttp_in_if  in_ch ();
  rttp_out_if out_ch ();

  int mismatch_count;
  int numbers_waiting;
  int numbers_checked;
  int flagged_numbers;

  int   bytes_sent     = 0;
  int   idle_cycles    = 0;
  int   send_idle_pct  = 0;   // percent of cycles the sender sits out
  int   recv_stall_pct = 0;   // percent of cycles the receiver refuses
  logic recv_hold      = 1'b0;

  register_text_token_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  register_text_token_parser_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count  (mismatch_count),
    .numbers_waiting (numbers_waiting),
    .numbers_checked (numbers_checked),
    .flagged_numbers (flagged_numbers)
  );

  always #6 clk = ~clk;

  // Receiver: random stalls, or a solid hold-off while recv_hold is up.
  always @(negedge clk) begin
    if (!rst_n || recv_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: any request moving on either side restarts the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one text byte; starts and ends at a falling edge.
  task automatic send_byte(input logic [TEXT_W-1:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= c;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Sender stops until every number is back, then lets the pipe settle
  // (bytes that make no number may still be in flight).
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (numbers_waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [TEXT_W-1:0] pick_delim();
    case ($urandom_range(0, 6))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_CR;
      4:       return CH_COMMA;
      5:       return CH_LBRACE;
      default: return CH_RBRACE;
    endcase
  endfunction

  // any byte that joins a token: no NUL, separator or slash
  function automatic logic [TEXT_W-1:0] pick_token_char();
    logic [TEXT_W-1:0] c;
    c = TEXT_W'($urandom_range(1, 255));
    while (c == CH_SLASH || c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_COMMA,
                                      CH_LBRACE, CH_RBRACE})
      c = TEXT_W'($urandom_range(1, 255));
    return c;
  endfunction

  task automatic push_digits(ref logic [TEXT_W-1:0] q[$], input int n);
    repeat (n) q.push_back(TEXT_W'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  // Mostly well-formed tokens with random content; some comments,
  // end-of-text markers and raw noise bytes mixed in.
  task automatic send_random_text(input int budget);
    logic [TEXT_W-1:0] chunk[$];
    logic [TEXT_W-1:0] c;
    int                start;
    int                kind;
    string             hex_digits;
    start      = bytes_sent;
    hex_digits = "0123456789abcdefABCDEF";
    while (bytes_sent - start < budget) begin
      chunk.delete();
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        push_digits(chunk, $urandom_range(1, 6));
      end else if (kind < 55) begin
        chunk.push_back(CH_ZERO);
        chunk.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
        repeat ($urandom_range(0, 5)) chunk.push_back(hex_digits[$urandom_range(0, 21)]);
      end else if (kind < 65) begin
        chunk.push_back(CH_ZERO);
        chunk.push_back($urandom_range(0, 1) ? CH_LC_B : CH_UC_B);
        repeat ($urandom_range(0, 18)) chunk.push_back(TEXT_W'(CH_ZERO + $urandom_range(0, 1)));
      end else if (kind < 73) begin
        repeat ($urandom_range(1, 4)) chunk.push_back(pick_token_char());
      end else if (kind < 81) begin
        // slash inside a token, or trailing right before a separator
        push_digits(chunk, $urandom_range(0, 3));
        chunk.push_back(CH_SLASH);
        push_digits(chunk, $urandom_range(0, 3));
      end else if (kind < 89) begin
        if ($urandom_range(0, 1)) push_digits(chunk, $urandom_range(1, 4));
        chunk.push_back(CH_SLASH);
        chunk.push_back(CH_SLASH);
        repeat ($urandom_range(0, 8)) begin
          c = TEXT_W'($urandom_range(1, 255));
          chunk.push_back(c == CH_LF ? CH_SPACE : c);
        end
        chunk.push_back($urandom_range(0, 7) == 0 ? CH_NUL : CH_LF);
      end else if (kind < 94) begin
        chunk.push_back(CH_NUL);
      end else begin
        repeat ($urandom_range(1, 3)) chunk.push_back(TEXT_W'($urandom_range(0, 255)));
      end
      // tokens usually close on a separator; sometimes two run together
      if (kind < 81 && $urandom_range(0, 5) != 0) begin
        chunk.push_back(pick_delim());
        if ($urandom_range(0, 3) == 0) chunk.push_back(pick_delim());
      end
      foreach (chunk[i]) send_byte(chunk[i]);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.text_byte = '0;
    out_ch.ready    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: hex prefixes in both cases, a binary prefix, slash before a
    // separator and before end of text, bare "0X", a digit below '0',
    // a high byte, a token cut by a comment, end of text inside a comment.
    send_text("0x1F,0b1 9/ 0X\t!{");
    send_byte(8'hFF);
    send_text("}7//c");
    send_byte(CH_NUL);
    send_text("5/");
    send_byte(CH_NUL);
    wait_drained();

    // Receiver held off for a long stretch while bytes keep coming,
    // so the output fills and the input request stalls; the sender
    // then drops its request and waits for every number.
    fork
      begin
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        recv_hold <= 1'b0;
      end
      begin
        send_random_text(80);
        wait_drained();
      end
    join

    // Idle/stall mixes: none, sender only, receiver only, both.
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random_text(PHASE_BYTES);
    send_idle_pct = 47; recv_stall_pct = 0;  send_random_text(PHASE_BYTES);
    wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 47; send_random_text(PHASE_BYTES);
    send_idle_pct = 22; recv_stall_pct = 22; send_random_text(PHASE_BYTES);

    // close the last text so any open token comes out
    send_byte(CH_NUL);
    wait_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d text bytes over hold-off and four idle/stall mixes", bytes_sent);
    $display("checked %0d numbers, %0d of them flagged bad", numbers_checked,
             flagged_numbers);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[register_text_token_parser.f]
rtl/rttp_pkg.sv
rtl/rttp_if.sv
rtl/register_text_token_parser.sv
verif/register_text_token_parser_checker.sv
verif/register_text_token_parser_tb.sv
